// ===== src/spm_pkg.sv =====
// Shared constants and types for the sparse polynomial multiplier.
`default_nettype none
package spm_pkg;

    localparam int MAX_TERMS = 8;
    localparam int COEF_BITS = 16;
    localparam int EXP_BITS  = 10;

    localparam int IDX_W   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W   = $clog2(MAX_TERMS + 1);
    localparam int PROD_W  = 2 * COEF_BITS;
    localparam int ESUM_W  = EXP_BITS + 1;
    localparam int ACC_W   = PROD_W + 2 * IDX_W + 1;
    localparam int OCOEF_W = 40;
    localparam int OEXP_W  = 11;
    localparam int SUM_W   = (ACC_W > OCOEF_W) ? ACC_W : OCOEF_W + 1;

    typedef enum logic [1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_MUL    = 2'd2
    } opcode_t;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic first;
        logic rescan;
        logic issue;
        logic emit;
        logic emit_empty;
        logic clear;
    } spm_cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic pair_last;
        logic pipe_busy;
        logic lower;
        logic out_free;
    } spm_sts_t;

endpackage
`default_nettype wire

// ===== src/spm_ctrl.sv =====
// Controller state machine: load, scan, drain and emit sequencing.
`default_nettype none
module spm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    input  wire logic [1:0]        s_tuser,
    output logic                   s_tready,
    output spm_pkg::spm_cmd_t      cmd,
    input  wire spm_pkg::spm_sts_t sts
);
    import spm_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_EMIT  = 5'b01000,
        S_EMPTY = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   take;

    assign s_tready = (state_reg == S_IDLE);
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load_a = take && (s_tuser == OP_LOAD_A);
                cmd.load_b = take && (s_tuser == OP_LOAD_B);
                if (take && (s_tuser == OP_MUL))
                begin
                    if (sts.cnt_zero)
                    begin
                        state_next = S_EMPTY;
                    end
                    else
                    begin
                        cmd.first  = 1'b1;
                        cmd.rescan = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.issue = 1'b1;
                if (sts.pair_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.lower)
                    begin
                        cmd.rescan = 1'b1;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_EMPTY:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_empty = 1'b1;
                    cmd.clear      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/spm_dp.sv =====
// Datapath: term stores, pair scan, multiplier, max-exponent accumulator, output register.
`default_nettype none
module spm_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire spm_pkg::spm_cmd_t cmd,
    output spm_pkg::spm_sts_t      sts,
    input  wire logic [15:0]       in_coef,
    input  wire logic [9:0]        in_exp,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [55:0]            m_tdata,
    output logic [1:0]             m_tuser,
    output logic                   m_tlast
);
    import spm_pkg::*;

    logic signed [COEF_BITS-1:0] a_coef [MAX_TERMS];
    logic signed [COEF_BITS-1:0] b_coef [MAX_TERMS];
    logic [EXP_BITS-1:0]         a_exp  [MAX_TERMS];
    logic [EXP_BITS-1:0]         b_exp  [MAX_TERMS];
    logic [CNT_W-1:0]            cnt_a_reg, cnt_b_reg;
    logic                        ovf_reg;
    logic [IDX_W-1:0]            i_reg, j_reg;

    logic signed [PROD_W-1:0]    prod_reg;
    logic [ESUM_W-1:0]           esum_reg;
    logic                        v1_reg;

    logic signed [ACC_W-1:0]     acc_reg, acc_next;
    logic [ESUM_W-1:0]           best_reg, best_next;
    logic                        found_reg, found_next;
    logic                        lower_reg, lower_next;
    logic [ESUM_W-1:0]           thr_reg;
    logic                        first_reg;

    logic signed [OCOEF_W-1:0]   ocoef_reg;
    logic [OEXP_W-1:0]           oexp_reg;
    logic                        olast_reg, oempty_reg, odrop_reg, ovalid_reg;

    logic signed [COEF_BITS-1:0] ld_coef;
    logic [EXP_BITS-1:0]         ld_exp;
    logic                        a_full, b_full, j_last, eligible;
    logic signed [SUM_W-1:0]     sum_ext;
    logic signed [OCOEF_W-1:0]   sum_sat;

    assign ld_coef = COEF_BITS'(signed'(in_coef));
    assign ld_exp  = EXP_BITS'(in_exp);
    assign a_full  = (cnt_a_reg == CNT_W'(MAX_TERMS));
    assign b_full  = (cnt_b_reg == CNT_W'(MAX_TERMS));
    assign j_last  = (j_reg == IDX_W'(cnt_b_reg - CNT_W'(1)));

    assign sts.cnt_zero  = (cnt_a_reg == '0) || (cnt_b_reg == '0);
    assign sts.pair_last = j_last && (i_reg == IDX_W'(cnt_a_reg - CNT_W'(1)));
    assign sts.pipe_busy = v1_reg;
    assign sts.lower     = lower_reg;
    assign sts.out_free  = !ovalid_reg || m_tready;

    // term stores and counts
    always_ff @(posedge clk)
    begin
        if (cmd.load_a && !a_full)
        begin
            a_coef[cnt_a_reg[IDX_W-1:0]] <= ld_coef;
            a_exp[cnt_a_reg[IDX_W-1:0]]  <= ld_exp;
        end
        if (cmd.load_b && !b_full)
        begin
            b_coef[cnt_b_reg[IDX_W-1:0]] <= ld_coef;
            b_exp[cnt_b_reg[IDX_W-1:0]]  <= ld_exp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.clear)
        begin
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load_a && !a_full)
            begin
                cnt_a_reg <= cnt_a_reg + CNT_W'(1);
            end
            if (cmd.load_b && !b_full)
            begin
                cnt_b_reg <= cnt_b_reg + CNT_W'(1);
            end
            if ((cmd.load_a && a_full) || (cmd.load_b && b_full))
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // pair counters and multiply stage
    always_ff @(posedge clk)
    begin
        if (cmd.rescan)
        begin
            i_reg <= '0;
            j_reg <= '0;
        end
        else if (cmd.issue)
        begin
            if (j_last)
            begin
                j_reg <= '0;
                i_reg <= i_reg + IDX_W'(1);
            end
            else
            begin
                j_reg <= j_reg + IDX_W'(1);
            end
        end
        prod_reg <= PROD_W'(a_coef[i_reg]) * PROD_W'(b_coef[j_reg]);
        esum_reg <= ESUM_W'(a_exp[i_reg]) + ESUM_W'(b_exp[j_reg]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
        end
    end

    // keep the highest exponent below the last emitted one (any exponent on the first scan), summing its products
    assign eligible = first_reg || (esum_reg < thr_reg);

    always_comb
    begin
        acc_next   = acc_reg;
        best_next  = best_reg;
        found_next = found_reg;
        lower_next = lower_reg;
        if (cmd.rescan)
        begin
            found_next = 1'b0;
            lower_next = 1'b0;
        end
        else if (v1_reg && eligible)
        begin
            found_next = 1'b1;
            if (!found_reg || (esum_reg > best_reg))
            begin
                best_next  = esum_reg;
                acc_next   = ACC_W'(prod_reg);
                lower_next = found_reg;
            end
            else if (esum_reg == best_reg)
            begin
                acc_next = acc_reg + ACC_W'(prod_reg);
            end
            else
            begin
                lower_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        best_reg  <= best_next;
        found_reg <= found_next;
        lower_reg <= lower_next;
        if (cmd.first)
        begin
            first_reg <= 1'b1;
        end
        else if (cmd.emit)
        begin
            first_reg <= 1'b0;
        end
        if (cmd.emit)
        begin
            thr_reg <= best_reg;
        end
    end

    // clamp to the 40-bit result range
    always_comb
    begin
        sum_ext = SUM_W'(acc_reg);
        if (sum_ext > SUM_W'(signed'({1'b0, {(OCOEF_W-1){1'b1}}})))
        begin
            sum_sat = {1'b0, {(OCOEF_W-1){1'b1}}};
        end
        else if (sum_ext < SUM_W'(signed'({1'b1, {(OCOEF_W-1){1'b0}}})))
        begin
            sum_sat = {1'b1, {(OCOEF_W-1){1'b0}}};
        end
        else
        begin
            sum_sat = OCOEF_W'(sum_ext);
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            ocoef_reg  <= sum_sat;
            oexp_reg   <= OEXP_W'(best_reg);
            olast_reg  <= !lower_reg;
            oempty_reg <= 1'b0;
            odrop_reg  <= ovf_reg;
        end
        else if (cmd.emit_empty)
        begin
            ocoef_reg  <= '0;
            oexp_reg   <= '0;
            olast_reg  <= 1'b1;
            oempty_reg <= 1'b1;
            odrop_reg  <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (cmd.emit || cmd.emit_empty)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {5'b0, oexp_reg, ocoef_reg};
    assign m_tuser  = {odrop_reg, oempty_reg};
    assign m_tlast  = olast_reg;

endmodule
`default_nettype wire

// ===== src/sparse_polynomial_multiply.sv =====
// Sparse polynomial multiplier top level.
//
// Input stream (s_*): one request per term load or multiply. s_tuser holds
// the opcode (load first, load second, multiply); s_tdata holds the term.
// Loads are taken one per cycle while the block is idle; terms past the capacity of eight are
// discarded and reported through the dropped flag of the next product.
// A multiply holds s_tready low until its final result sits in the output
// register. Results leave in descending exponent order, one per distinct
// exponent, equal-exponent products summed; m_tlast marks the final one.
// If either polynomial is empty, one result with the empty flag comes out.
// Each result takes one scan of all n1*n2 term pairs through the registered
// multiplier and the max-exponent accumulator, followed by a drain and an
// emit. The empty case goes to the empty state and emits once the output
// register is free. A stalled receiver holds the output register and pauses
// the controller before the next emit.
// Reset clears the counts, the drop flag and all valid state; the term
// stores need no clearing since only entries below the counts are read.
`default_nettype none
module sparse_polynomial_multiply (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // term_coef[15:0], term_exp[25:16], zero pad
    input  wire logic [1:0]  s_tuser,   // opcode[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // out_coef[39:0], out_exp[50:40], zero pad
    output logic [1:0]       m_tuser,   // empty_res[0], dropped[1]
    output logic             m_tlast
);
    import spm_pkg::*;

    spm_cmd_t cmd;
    spm_sts_t sts;

    spm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    spm_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .in_coef  (s_tdata[15:0]),
        .in_exp   (s_tdata[25:16]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

// ===== src/spm_checker.sv =====
// Port-level checks for the sparse polynomial multiplier, bound to the top level.
`default_nettype none
module spm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);
    import spm_pkg::*;

    a_mul_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == OP_MUL) |=> !s_tready)
        else $error("input not stalled after multiply request");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == '0))
        else $error("empty result malformed");

    a_load_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid && s_tready |=> !m_tvalid)
        else $error("result appeared without a multiply");

endmodule

bind sparse_polynomial_multiply spm_checker u_spm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
